// ===== src/hpd_pkg.sv =====
// hpd_pkg: shared types and constants of the heading pd controller
// word structs, config bundle, register indexes, cordic arctangent table
// no dependencies
package hpd_pkg;

    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int CORDIC_XW = 36;   // holds 2^32.5 * 1.647 with sign
    localparam int ARC_DEPTH = 24;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ARC_TAB [ARC_DEPTH] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic [15:0] PROP_GAIN_RST   = 16'd2011;
    localparam logic [15:0] DERIV_GAIN_RST  = 16'd251;
    localparam logic [13:0] BASE_SPEED_RST  = 14'd7680;
    localparam logic [13:0] MAX_TURN_RST    = 14'd7680;
    localparam logic [14:0] REV_THRESH_RST  = 15'd18022;

    typedef enum logic [2:0] {
        REG_PROP_GAIN,
        REG_DERIV_GAIN,
        REG_BASE_SPEED,
        REG_MAX_TURN,
        REG_REV_THRESH
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] robot_x;
        logic signed [15:0] robot_y;
        logic signed [15:0] robot_heading;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic [3:0]         robot_tag;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic               reversed_drive;
        logic [3:0]         tag_out;
    } out_word_t;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] deriv_gain;
        logic [13:0] base_speed;
        logic [13:0] max_turn;
        logic [14:0] reverse_threshold;
    } cfg_t;

    // per-word fields that ride along the cordic pipeline
    typedef struct packed {
        logic [15:0] robot_heading;
        logic [3:0]  robot_tag;
        logic        is_zero;
    } side_t;

endpackage

// ===== src/hpd_cfg_regs.sv =====
// hpd_cfg_regs: apb register file for gains, speeds and reversal threshold
// depends on hpd_pkg
module hpd_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [hpd_pkg::APB_AW-1:0] paddr,
    input  logic [hpd_pkg::APB_DW-1:0] pwdata,
    output logic [hpd_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output hpd_pkg::cfg_t             cfg
);
    import hpd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain         <= PROP_GAIN_RST;
            cfg_reg.deriv_gain        <= DERIV_GAIN_RST;
            cfg_reg.base_speed        <= BASE_SPEED_RST;
            cfg_reg.max_turn          <= MAX_TURN_RST;
            cfg_reg.reverse_threshold <= REV_THRESH_RST;
        end else if (wr_en) begin
            case (idx)
                REG_PROP_GAIN:  cfg_reg.prop_gain         <= pwdata[15:0];
                REG_DERIV_GAIN: cfg_reg.deriv_gain        <= pwdata[15:0];
                REG_BASE_SPEED: cfg_reg.base_speed        <= pwdata[13:0];
                REG_MAX_TURN:   cfg_reg.max_turn          <= pwdata[13:0];
                REG_REV_THRESH: cfg_reg.reverse_threshold <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PROP_GAIN:  prdata = {16'd0, cfg_reg.prop_gain};
            REG_DERIV_GAIN: prdata = {16'd0, cfg_reg.deriv_gain};
            REG_BASE_SPEED: prdata = {18'd0, cfg_reg.base_speed};
            REG_MAX_TURN:   prdata = {18'd0, cfg_reg.max_turn};
            REG_REV_THRESH: prdata = {17'd0, cfg_reg.reverse_threshold};
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== src/hpd_cordic_stage.sv =====
// hpd_cordic_stage: one registered vectoring iteration of the bearing cordic
// depends on hpd_pkg
module hpd_cordic_stage #(
    parameter int ANGLE_BITS = 16,
    parameter int IDX        = 0,
    parameter int ZW         = 26
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [hpd_pkg::CORDIC_XW-1:0] x_in,
    input  logic signed [hpd_pkg::CORDIC_XW-1:0] y_in,
    input  logic signed [ZW-1:0]                z_in,
    input  hpd_pkg::side_t                      side_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hpd_pkg::CORDIC_XW-1:0] x_out,
    output logic signed [hpd_pkg::CORDIC_XW-1:0] y_out,
    output logic signed [ZW-1:0]                z_out,
    output hpd_pkg::side_t                      side_out
);
    import hpd_pkg::*;

    localparam logic signed [ZW-1:0] STEP = ZW'(ARC_TAB[IDX] >> (ARC_DEPTH - ANGLE_BITS));

    logic                        vld_reg;
    logic signed [CORDIC_XW-1:0] x_reg, y_reg, x_next, y_next, x_sh, y_sh;
    logic signed [ZW-1:0]        z_reg, z_next;
    side_t                       side_reg;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

    always_comb begin
        x_sh = x_in >>> IDX;
        y_sh = y_in >>> IDX;
        // y non-negative: rotate clockwise
        if (!y_in[CORDIC_XW-1]) begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + STEP;
        end else begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

endmodule

// ===== src/hpd_pd_ctrl.sv =====
// hpd_pd_ctrl: bearing rounding, heading error, reversal, pd term and wheel mix
// five registered stages, the last one is the result register; depends on hpd_pkg
module hpd_pd_ctrl #(
    parameter int ANGLE_BITS = 16,
    parameter int ZW         = 26
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hpd_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [ZW-1:0] z_in,
    input  hpd_pkg::side_t       side_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hpd_pkg::out_word_t   m_data
);
    import hpd_pkg::*;

    localparam int NST = 5;
    localparam logic signed [ZW-1:0] RND = ZW'(1) << (ANGLE_BITS - 9);

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;
    logic [NST-1:0] vin;

    // stage a: bearing and raw error
    logic signed [ZW-1:0] z_rnd;
    logic [15:0]          brg;
    logic signed [15:0]   err_a_reg, err_a_next;
    logic [3:0]           tag_a_reg;
    // stage b: reversal and error change
    logic signed [15:0]   err_b_reg, err_b_next, prev_err_reg;
    logic signed [16:0]   diff_b_reg, diff_b_next;
    logic [15:0]          mag;
    logic                 rev_b_reg, rev_b_next;
    logic [3:0]           tag_b_reg;
    // stage c: products
    logic signed [32:0]   prod_p_reg, prod_p_next;
    logic signed [33:0]   prod_d_reg, prod_d_next;
    logic                 rev_c_reg;
    logic [3:0]           tag_c_reg;
    // stage d: saturated turn term
    logic signed [34:0]   sum;
    logic signed [22:0]   shifted, lim;
    logic signed [14:0]   turn_reg, turn_next;
    logic                 rev_d_reg;
    logic [3:0]           tag_d_reg;
    // stage e: wheel mix
    logic signed [16:0]   b, m, l, r;
    out_word_t            out_reg, out_next;

    always_comb begin
        rdy[NST] = m_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vin      = {vld_reg[NST-2:0], in_valid};
    assign in_ready = rdy[0];
    assign m_valid  = vld_reg[NST-1];
    assign m_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vin[k];
                end
            end
        end
    end

    // stage a
    always_comb begin
        z_rnd      = z_in + RND;
        brg        = side_in.is_zero ? 16'd0 : z_rnd[ANGLE_BITS-8 +: 16];
        err_a_next = $signed(side_in.robot_heading - brg);
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            err_a_reg <= err_a_next;
            tag_a_reg <= side_in.robot_tag;
        end
    end

    // stage b; a half-turn error has magnitude 32768 and always reverses
    always_comb begin
        mag         = err_a_reg[15] ? 16'(-err_a_reg) : err_a_reg;
        rev_b_next  = mag > {1'b0, cfg.reverse_threshold};
        err_b_next  = rev_b_next ? (err_a_reg ^ 16'sh8000) : err_a_reg;
        diff_b_next = 17'(err_b_next) - 17'(prev_err_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
        end else if (rdy[1] && vin[1]) begin
            prev_err_reg <= err_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            err_b_reg  <= err_b_next;
            diff_b_reg <= diff_b_next;
            rev_b_reg  <= rev_b_next;
            tag_b_reg  <= tag_a_reg;
        end
    end

    // stage c
    always_comb begin
        prod_p_next = $signed({1'b0, cfg.prop_gain}) * err_b_reg;
        prod_d_next = $signed({1'b0, cfg.deriv_gain}) * diff_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            prod_p_reg <= prod_p_next;
            prod_d_reg <= prod_d_next;
            rev_c_reg  <= rev_b_reg;
            tag_c_reg  <= tag_b_reg;
        end
    end

    // stage d: floor divide by 4096 and clamp to +-max_turn
    always_comb begin
        sum     = 35'(prod_p_reg) + 35'(prod_d_reg);
        shifted = sum[34:12];
        lim     = $signed({9'd0, cfg.max_turn});
        if (shifted > lim) begin
            turn_next = 15'(lim);
        end else if (shifted < -lim) begin
            turn_next = 15'(-lim);
        end else begin
            turn_next = 15'(shifted);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            turn_reg  <= turn_next;
            rev_d_reg <= rev_c_reg;
            tag_d_reg <= tag_c_reg;
        end
    end

    // stage e
    always_comb begin
        b = $signed({3'd0, cfg.base_speed});
        m = 17'(turn_reg);
        if (!rev_d_reg) begin
            if (m > 0) begin
                l = b;
                r = b - m;
            end else begin
                l = b + m;
                r = b;
            end
        end else begin
            if (m > 0) begin
                l = m - b;
                r = -b;
            end else begin
                l = -b;
                r = -b - m;
            end
        end
        out_next.left_speed     = l[15:0];
        out_next.right_speed    = r[15:0];
        out_next.reversed_drive = rev_d_reg;
        out_next.tag_out        = tag_d_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            out_reg <= out_next;
        end
    end

    // turn term never leaves the clamp window
    a_turn_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] |-> (turn_reg <= $signed({1'b0, cfg.max_turn})
                        && turn_reg >= -$signed({1'b0, cfg.max_turn})))
        else $error("turn term outside clamp");

    // forward drive keeps one wheel at base speed
    a_fwd_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.reversed_drive) |->
            (m_data.left_speed == {2'b00, cfg.base_speed}
             || m_data.right_speed == {2'b00, cfg.base_speed}))
        else $error("forward mix lost base speed");

    // reversed drive keeps one wheel at minus base speed
    a_rev_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.reversed_drive) |->
            (m_data.left_speed == 16'(16'd0 - {2'b00, cfg.base_speed})
             || m_data.right_speed == 16'(16'd0 - {2'b00, cfg.base_speed})))
        else $error("reversed mix lost base speed");

    // stored error only moves when a word passes the reversal stage
    a_prev_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rdy[1] && vin[1]) |=> $stable(prev_err_reg))
        else $error("previous error changed without a word");

endmodule

// ===== src/heading_pd_differential_drive.sv =====
// heading_pd_differential_drive: top level of the heading pd controller
// instantiates hpd_cfg_regs, hpd_cordic_stage and hpd_pd_ctrl; depends on hpd_pkg

// Each input word carries robot position, heading and a target point and yields
// exactly one result word with left and right wheel speeds (signed Q8.8), a
// reversed-drive flag and the robot tag. The bearing to the target comes from a
// vectoring cordic with one iteration per pipeline stage; heading error, the
// reversal decision, the pd term against the stored previous error and the wheel
// mix follow in five more stages. The block takes one word every clock when the
// output side keeps up; a word passes the prep register, the cordic stages and
// the five pd stages on its way out. Every stage has its own valid bit, so
// bubbles close up while the output is stalled and new words keep coming in
// until the pipeline is full. Registers sit on the apb port at byte offsets
// 0x00 prop_gain, 0x04 deriv_gain, 0x08 base_speed, 0x0c max_turn,
// 0x10 reverse_threshold; write them only while no word is in flight.
module heading_pd_differential_drive #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input words
    input  logic                       s_valid,
    output logic                       s_ready,
    input  hpd_pkg::in_word_t          s_data,
    // result words
    output logic                       m_valid,
    input  logic                       m_ready,
    output hpd_pkg::out_word_t         m_data,
    // apb config port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hpd_pkg::APB_AW-1:0] paddr,
    input  logic [hpd_pkg::APB_DW-1:0] pwdata,
    output logic [hpd_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import hpd_pkg::*;

    // angle accumulator in 2^-(ANGLE_BITS+8) turn, room for 0.8 turn plus sign
    localparam int ZW = ANGLE_BITS + 10;
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(1) << (ANGLE_BITS + 7);

    cfg_t cfg;

    // prep stage: differences, left half-plane fold, scale by 2^16
    logic                        prep_vld_reg;
    logic signed [CORDIC_XW-1:0] prep_x_reg, prep_y_reg, prep_x_next, prep_y_next;
    logic signed [ZW-1:0]        prep_z_reg, prep_z_next;
    side_t                       prep_side_reg, prep_side_next;
    logic signed [16:0]          dx, dy;
    logic signed [17:0]          ax, ay;

    // cordic chain, index 0 is the prep stage output
    logic                        c_vld [CORDIC_STEPS+1];
    logic                        c_rdy [CORDIC_STEPS+1];
    logic signed [CORDIC_XW-1:0] c_x   [CORDIC_STEPS+1];
    logic signed [CORDIC_XW-1:0] c_y   [CORDIC_STEPS+1];
    logic signed [ZW-1:0]        c_z   [CORDIC_STEPS+1];
    side_t                       c_side[CORDIC_STEPS+1];

    hpd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb begin
        dx = 17'(s_data.target_x) - 17'(s_data.robot_x);
        dy = 17'(s_data.target_y) - 17'(s_data.robot_y);
        // target behind the y axis: turn the vector by half a turn first
        if (dx[16]) begin
            ax          = -18'(dx);
            ay          = -18'(dy);
            prep_z_next = HALF_TURN;
        end else begin
            ax          = 18'(dx);
            ay          = 18'(dy);
            prep_z_next = '0;
        end
        // scaled values keep their sign across the widening
        prep_x_next                  = CORDIC_XW'($signed({ax, 16'd0}));
        prep_y_next                  = CORDIC_XW'($signed({ay, 16'd0}));
        prep_side_next.robot_heading = s_data.robot_heading;
        prep_side_next.robot_tag     = s_data.robot_tag;
        // target on robot: bearing forced to zero
        prep_side_next.is_zero       = (dx == 17'sd0) && (dy == 17'sd0);
    end

    assign s_ready = !prep_vld_reg || c_rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_vld_reg <= 1'b0;
        end else if (s_ready) begin
            prep_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            prep_x_reg    <= prep_x_next;
            prep_y_reg    <= prep_y_next;
            prep_z_reg    <= prep_z_next;
            prep_side_reg <= prep_side_next;
        end
    end

    assign c_vld[0]  = prep_vld_reg;
    assign c_x[0]    = prep_x_reg;
    assign c_y[0]    = prep_y_reg;
    assign c_z[0]    = prep_z_reg;
    assign c_side[0] = prep_side_reg;

    // one vectoring iteration per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        hpd_cordic_stage #(
            .ANGLE_BITS (ANGLE_BITS),
            .IDX        (i),
            .ZW         (ZW)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_vld[i]),
            .in_ready  (c_rdy[i]),
            .x_in      (c_x[i]),
            .y_in      (c_y[i]),
            .z_in      (c_z[i]),
            .side_in   (c_side[i]),
            .out_valid (c_vld[i+1]),
            .out_ready (c_rdy[i+1]),
            .x_out     (c_x[i+1]),
            .y_out     (c_y[i+1]),
            .z_out     (c_z[i+1]),
            .side_out  (c_side[i+1])
        );
    end

    // error, reversal, pd term, wheel mix and result register
    hpd_pd_ctrl #(
        .ANGLE_BITS (ANGLE_BITS),
        .ZW         (ZW)
    ) u_pd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (c_vld[CORDIC_STEPS]),
        .in_ready (c_rdy[CORDIC_STEPS]),
        .z_in     (c_z[CORDIC_STEPS]),
        .side_in  (c_side[CORDIC_STEPS]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // a word is taken only when the prep slot frees up
    a_accept_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (prep_vld_reg && !c_rdy[0]) |-> !s_ready)
        else $error("input taken while prep stage is blocked");

    // an accepted word always shows up in the prep stage
    a_prep_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> prep_vld_reg)
        else $error("accepted word lost at prep stage");

    // a blocked prep stage keeps its word
    a_prep_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (prep_vld_reg && !c_rdy[0]) |=> (prep_vld_reg && $stable(prep_z_reg)))
        else $error("prep stage dropped a blocked word");

endmodule
